// ===== hw/rtl/pbpm_pkg.sv =====
// Shared types and constants for the PCM buffer peak level meter.
package pbpm_pkg;

  localparam int MaxChannelsDef = 8;
  localparam int CfgIdxW        = 2;
  localparam int CfgDataW       = 4;
  localparam int QueueDepth     = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFormat   = 2'd0,
    CfgEndian   = 2'd1,
    CfgChannels = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FmtU8   = 3'd0,
    FmtS8   = 3'd1,
    FmtU16  = 3'd2,
    FmtS16  = 3'd3,
    FmtNone = 3'd4
  } fmt_e;

  localparam logic [3:0] ChannelsRst = 4'd1;

  typedef struct packed {
    fmt_e        fmt;
    logic [15:0] peak;
  } entry_t;

endpackage

// ===== hw/rtl/pcm_buffer_peak_level_meter.sv =====
// Top level of the PCM buffer peak level meter.
// Takes one PCM byte per cycle with no bubbles unless the input stalls; the front
// end assembles samples and tracks the peak over complete frames, and the byte flagged
// last hands the buffer peak to a two-entry queue. The back end scales it to a Q0.16
// volume with constant multiplies into the output register. Input stalls only while
// the queue holds two unread results behind an occupied output register. Writes to
// the format, endian or channel registers restart the buffer in progress.
module pcm_buffer_peak_level_meter #(
  parameter int MAX_CHANNELS = pbpm_pkg::MaxChannelsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pbpm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pbpm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [15:0]                   volume_o
);

  pbpm_pkg::entry_t push_entry, head_entry;
  logic             push, full, pop, empty;

  pbpm_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .data_byte_i,
    .last_i,
    .push_o  (push),
    .entry_o (push_entry),
    .full_i  (full)
  );

  pbpm_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (head_entry)
  );

  pbpm_back u_back (
    .clk_i,
    .rst_ni,
    .entry_i (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .out_valid_o,
    .out_stall_i,
    .volume_o
  );

endmodule

// ===== hw/rtl/pbpm_front.sv =====
// Front end: configuration registers, sample assembly and peak tracking per buffer.
module pbpm_front #(
  parameter int MAX_CHANNELS = pbpm_pkg::MaxChannelsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pbpm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pbpm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           last_i,
  output logic                           push_o,
  output pbpm_pkg::entry_t               entry_o,
  input  logic                           full_i
);

  localparam int ChW  = $clog2(MAX_CHANNELS + 1);
  localparam int IdxW = $clog2(2 * MAX_CHANNELS);
  localparam int FbW  = $clog2(2 * MAX_CHANNELS + 1);

  pbpm_pkg::fmt_e  fmt_q;
  logic            be_q;
  logic [3:0]      cc_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      held_q, held_d;
  logic [15:0]     fpeak_q, fpeak_d;
  logic [15:0]     bpeak_q, bpeak_d;

  logic            accept, supported, wide, have;
  logic [ChW-1:0]  ch_used;
  logic [FbW-1:0]  frame_bytes, idx_inc;
  logic            frame_done;
  logic [15:0]     word, mag, fpeak_upd, bpeak_upd;
  logic [7:0]      neg_b;
  logic            cfg_hit;

  assign accept     = in_valid_i & ~in_stall_o;
  assign in_stall_o = full_i;

  always_comb begin
    if (cc_q == 4'd0) begin
      ch_used = ChW'(1);
    end else if (32'(cc_q) > 32'(MAX_CHANNELS)) begin
      ch_used = ChW'(MAX_CHANNELS);
    end else begin
      ch_used = ChW'(cc_q);
    end
  end

  always_comb begin
    supported = 1'b1;
    wide      = 1'b0;
    have      = 1'b0;
    mag       = '0;
    held_d    = held_q;
    neg_b     = ~data_byte_i + 8'd1;
    word      = be_q ? {held_q, data_byte_i} : {data_byte_i, held_q};
    case (fmt_q)
      pbpm_pkg::FmtU8: begin
        have = 1'b1;
        mag  = {8'd0, data_byte_i};
      end
      pbpm_pkg::FmtS8: begin
        have = 1'b1;
        mag  = {8'd0, data_byte_i[7] ? neg_b : data_byte_i};
      end
      pbpm_pkg::FmtU16, pbpm_pkg::FmtS16: begin
        wide = 1'b1;
        if (!idx_q[0]) begin
          held_d = data_byte_i;
        end else begin
          have = 1'b1;
          mag  = (fmt_q == pbpm_pkg::FmtS16 && word[15]) ? (~word + 16'd1) : word;
        end
      end
      default: begin
        supported = 1'b0;
      end
    endcase
  end

  assign frame_bytes = wide ? FbW'({ch_used, 1'b0}) : FbW'(ch_used);
  assign idx_inc     = FbW'(idx_q) + FbW'(1);
  assign frame_done  = idx_inc >= frame_bytes;
  assign fpeak_upd   = (have && mag > fpeak_q) ? mag : fpeak_q;
  assign bpeak_upd   = (frame_done && fpeak_upd > bpeak_q) ? fpeak_upd : bpeak_q;

  assign push_o        = accept & last_i;
  assign entry_o.fmt   = fmt_q;
  assign entry_o.peak  = bpeak_upd;

  assign cfg_hit = cfg_we_i && (cfg_index_i == pbpm_pkg::CfgFormat ||
                                cfg_index_i == pbpm_pkg::CfgEndian ||
                                cfg_index_i == pbpm_pkg::CfgChannels);

  logic [IdxW-1:0] idx_n;
  logic [7:0]      held_n;
  logic [15:0]     fpeak_n, bpeak_n;
  logic [7:0]      held_d2;

  always_comb begin
    idx_n   = idx_q;
    held_n  = held_q;
    fpeak_n = fpeak_q;
    bpeak_n = bpeak_q;
    if (accept && supported) begin
      held_n  = held_d;
      bpeak_n = bpeak_upd;
      idx_n   = frame_done ? '0 : idx_inc[IdxW-1:0];
      fpeak_n = frame_done ? '0 : fpeak_upd;
    end
    idx_d   = idx_n;
    held_d2 = held_n;
    fpeak_d = fpeak_n;
    bpeak_d = bpeak_n;
    if (cfg_hit || (accept && last_i)) begin
      idx_d   = '0;
      held_d2 = '0;
      fpeak_d = '0;
      bpeak_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q   <= pbpm_pkg::FmtNone;
      be_q    <= 1'b0;
      cc_q    <= pbpm_pkg::ChannelsRst;
      idx_q   <= '0;
      held_q  <= '0;
      fpeak_q <= '0;
      bpeak_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          pbpm_pkg::CfgFormat:   fmt_q <= pbpm_pkg::fmt_e'(cfg_data_i[2:0]);
          pbpm_pkg::CfgEndian:   be_q  <= cfg_data_i[0];
          pbpm_pkg::CfgChannels: cc_q  <= cfg_data_i;
          default: ;
        endcase
      end
      idx_q   <= idx_d;
      held_q  <= held_d2;
      fpeak_q <= fpeak_d;
      bpeak_q <= bpeak_d;
    end
  end

endmodule

// ===== hw/rtl/pbpm_fifo.sv =====
// Short queue of buffer-end entries between front and back end.
module pbpm_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pbpm_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output pbpm_pkg::entry_t entry_o
);

  localparam int PtrW = $clog2(pbpm_pkg::QueueDepth);
  localparam int CntW = $clog2(pbpm_pkg::QueueDepth + 1);

  pbpm_pkg::entry_t mem_q [pbpm_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CntW'(pbpm_pkg::QueueDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (32'(wr_q) == pbpm_pkg::QueueDepth - 1) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (32'(rd_q) == pbpm_pkg::QueueDepth - 1) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

// ===== hw/rtl/pbpm_back.sv =====
// Back end: full-scale saturation, volume scaling and the result register.
module pbpm_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pbpm_pkg::entry_t entry_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [15:0]      volume_o
);

  logic        out_valid_q;
  logic [15:0] volume_q, volume_d;
  logic [15:0] prev_q, prev_d;
  logic [15:0] fs, sat, vol;
  logic        supported;
  logic [6:0]  p7;
  logic [8:0]  p3;
  logic [1:0]  q3;

  assign pop_o = ~empty_i & (~out_valid_q | ~out_stall_i);

  always_comb begin
    supported = 1'b1;
    case (entry_i.fmt)
      pbpm_pkg::FmtU8:  fs = 16'd255;
      pbpm_pkg::FmtS8:  fs = 16'd127;
      pbpm_pkg::FmtU16: fs = 16'd65535;
      pbpm_pkg::FmtS16: fs = 16'd32767;
      default: begin
        fs        = '0;
        supported = 1'b0;
      end
    endcase
  end

  assign sat = (entry_i.peak > fs) ? fs : entry_i.peak;

  // 65535/127 = 516 rem 3, so the fraction term is floor(3p/127)
  assign p7 = sat[6:0];
  assign p3 = {1'b0, p7, 1'b0} + {2'b0, p7};
  assign q3 = (p3 >= 9'd381) ? 2'd3 : (p3 >= 9'd254) ? 2'd2 : (p3 >= 9'd127) ? 2'd1 : 2'd0;

  always_comb begin
    case (entry_i.fmt)
      pbpm_pkg::FmtU8:  vol = {sat[7:0], sat[7:0]};
      pbpm_pkg::FmtS8:  vol = 16'({p7, 9'd0}) + 16'({p7, 2'd0}) + 16'(q3);
      pbpm_pkg::FmtU16: vol = sat;
      pbpm_pkg::FmtS16: vol = {sat[14:0], 1'b0} + 16'(sat == 16'd32767);
      default:          vol = prev_q;
    endcase
  end

  always_comb begin
    volume_d = volume_q;
    prev_d   = prev_q;
    if (pop_o) begin
      volume_d = vol;
      if (supported) begin
        prev_d = vol;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      prev_q      <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    volume_q <= volume_d;
  end

  assign out_valid_o = out_valid_q;
  assign volume_o    = volume_q;

endmodule

// ===== hw/rtl/pbpm_checker.sv =====
// Port-level checker for the PCM buffer peak level meter, with its bind.
module pbpm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [pbpm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [pbpm_pkg::CfgDataW-1:0] cfg_data_i,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [7:0]                    data_byte_i,
  input logic                          last_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [15:0]                   volume_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(volume_o))
    else $error("stalled volume changed");

  a_stall_backed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i && !out_valid_o |-> ##2 out_valid_o)
    else $error("buffer end gave no result");

endmodule

bind pcm_buffer_peak_level_meter pbpm_checker u_pbpm_checker (.*);

// ===== bench/volume_checker.sv =====
// Volume checker: predicts the per-buffer volume and compares it with what the block reports.
`timescale 1ns / 100ps

module volume_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pbpm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pbpm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           last_i,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  logic [15:0]                    volume_o,
  output int                             errors_o,
  output int                             pending_o
);

  logic [2:0]  fmt_reg;
  logic        endian_reg;
  logic [3:0]  chan_reg;
  logic [4:0]  byte_pos;
  logic [7:0]  first_byte;
  logic [15:0] frame_max;
  logic [15:0] buf_max;
  logic [15:0] held_volume;
  logic [15:0] want_volume;
  logic [15:0] volume_q[$];

  function automatic logic [15:0] scale_of(input logic [2:0] f);
    case (f)
      pbpm_pkg::FmtU8:  return 16'd255;
      pbpm_pkg::FmtS8:  return 16'd127;
      pbpm_pkg::FmtU16: return 16'd65535;
      pbpm_pkg::FmtS16: return 16'd32767;
      default:          return 16'd0;
    endcase
  endfunction

  task automatic restart_buffer();
    byte_pos   = '0;
    first_byte = '0;
    frame_max  = '0;
    buf_max    = '0;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic is_last);
    logic [15:0] fs;
    logic [15:0] mag;
    logic [15:0] word;
    logic [15:0] peak;
    logic        got;
    int          lanes;
    int          span;
    fs    = scale_of(fmt_reg);
    mag   = '0;
    got   = 1'b0;
    lanes = (chan_reg == 0) ? 1 : ((chan_reg > pbpm_pkg::MaxChannelsDef) ?
            pbpm_pkg::MaxChannelsDef : chan_reg);
    span  = (fmt_reg == pbpm_pkg::FmtU16 || fmt_reg == pbpm_pkg::FmtS16) ? 2 * lanes : lanes;
    if (fs != 0) begin
      case (fmt_reg)
        pbpm_pkg::FmtU8: begin
          mag = 16'(b);
          got = 1'b1;
        end
        pbpm_pkg::FmtS8: begin
          mag = b[7] ? 16'(9'd256 - b) : 16'(b);
          got = 1'b1;
        end
        default: begin
          if (!byte_pos[0]) begin
            first_byte = b;
          end else begin
            word = endian_reg ? {first_byte, b} : {b, first_byte};
            mag  = (fmt_reg == pbpm_pkg::FmtS16 && word[15]) ? 16'(17'h10000 - word) : word;
            got  = 1'b1;
          end
        end
      endcase
      if (got && mag > frame_max) frame_max = mag;
      byte_pos = byte_pos + 5'd1;
      if (byte_pos >= span) begin
        if (frame_max > buf_max) buf_max = frame_max;
        frame_max = '0;
        byte_pos  = '0;
      end
    end
    if (is_last) begin
      if (fs != 0) begin
        peak        = (buf_max < fs) ? buf_max : fs;
        held_volume = 16'((32'(peak) * 32'd65535) / 32'(fs));
      end
      volume_q.push_back(held_volume);
      restart_buffer();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_reg    = pbpm_pkg::FmtNone;
      endian_reg = 1'b0;
      chan_reg   = pbpm_pkg::ChannelsRst;
      restart_buffer();
      held_volume = '0;
      volume_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (volume_q.size() == 0) begin
          $display("%0t: volume %0d with none expected", $time, volume_o);
          errors_o++;
        end else begin
          want_volume = volume_q.pop_front();
          if (volume_o !== want_volume) begin
            $display("%0t: volume expected %0d, got %0d", $time, want_volume, volume_o);
            errors_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          pbpm_pkg::CfgFormat: begin
            fmt_reg = cfg_data_i[2:0];
            restart_buffer();
          end
          pbpm_pkg::CfgEndian: begin
            endian_reg = cfg_data_i[0];
            restart_buffer();
          end
          pbpm_pkg::CfgChannels: begin
            chan_reg = cfg_data_i;
            restart_buffer();
          end
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) take_byte(data_byte_i, last_i);
      pending_o = volume_q.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Testbench top: drives PCM bytes and settings into the peak level meter and reports the verdict.
`timescale 1ns / 100ps

module testbench;

  localparam logic [pbpm_pkg::CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int FmtCodeMax   = 7;
  localparam int ItemTarget   = 1800;
  localparam int CalmFrom     = 1500;
  localparam int SettleCycles = 4;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [pbpm_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [pbpm_pkg::CfgDataW-1:0] cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [7:0]                    data_byte_i;
  logic                          last_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [15:0]                   volume_o;

  int       errors;
  int       pending;
  int       sent_items;
  int       phase;
  bit       idle_on;
  logic [2:0] fmt_now;
  logic [3:0] chan_now;

  always #6 clk_i = ~clk_i;

  pcm_buffer_peak_level_meter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .data_byte_i(data_byte_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .volume_o   (volume_o)
  );

  volume_checker u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .data_byte_i(data_byte_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .volume_o   (volume_o),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  task automatic write_reg(input logic [pbpm_pkg::CfgIdxW-1:0] idx,
                           input logic [pbpm_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    if (idx == pbpm_pkg::CfgFormat) fmt_now = val[2:0];
    if (idx == pbpm_pkg::CfgChannels) chan_now = val;
  endtask

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic push_byte(input logic [7:0] b, input logic l);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_i      <= l;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    sent_items++;
    if (sent_items >= CalmFrom) idle_on = 1'b0;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] corner [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'h81, 8'hFF};
    if ($urandom_range(0, 3) == 0) return corner[$urandom_range(0, 5)];
    return 8'($urandom);
  endfunction

  function automatic int frame_len();
    int lanes;
    lanes = (chan_now == 0) ? 1 : ((chan_now > pbpm_pkg::MaxChannelsDef) ?
            pbpm_pkg::MaxChannelsDef : chan_now);
    return (fmt_now == pbpm_pkg::FmtU16 || fmt_now == pbpm_pkg::FmtS16) ? 2 * lanes : lanes;
  endfunction

  task automatic send_bytes(input int n, input logic close);
    for (int i = 0; i < n; i++) push_byte(pick_byte(), close && (i == n - 1));
  endtask

  // mostly whole frames, some with a torn tail, a few of arbitrary length
  task automatic send_buffer();
    int fb;
    int n;
    int roll;
    fb   = frame_len();
    roll = $urandom_range(0, 9);
    if (roll == 0) n = $urandom_range(1, 20);
    else if (roll == 1) n = $urandom_range(1, fb);
    else begin
      n = fb * $urandom_range(1, 3);
      if (roll < 4) n += $urandom_range(0, fb - 1);
    end
    send_bytes(n, 1'b1);
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(20, 60)) @(negedge clk_i);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    logic [3:0] chan_list [8];
    int         nbuf;
    chan_list   = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd9, 4'd3, 4'd8};
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = pbpm_pkg::CfgFormat;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_i      = 1'b0;
    sent_items  = 0;
    idle_on     = 1'b1;
    fmt_now     = pbpm_pkg::FmtNone;
    chan_now    = pbpm_pkg::ChannelsRst;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // out of reset the format is unsupported: repeats the zero volume
    push_byte(8'hA5, 1'b1);
    settle();
    write_reg(pbpm_pkg::CfgFormat, 4'(pbpm_pkg::FmtU8));
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h80, 1'b1);
    settle();
    write_reg(pbpm_pkg::CfgFormat, 4'(pbpm_pkg::FmtS8));
    push_byte(8'h80, 1'b1);
    push_byte(8'h7F, 1'b1);
    push_byte(8'h01, 1'b1);
    push_byte(8'hFF, 1'b1);
    settle();
    write_reg(pbpm_pkg::CfgFormat, 4'(pbpm_pkg::FmtU16));
    write_reg(pbpm_pkg::CfgChannels, 4'd2);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b1);
    settle();
    write_reg(pbpm_pkg::CfgFormat, 4'(pbpm_pkg::FmtS16));
    write_reg(pbpm_pkg::CfgEndian, 4'd1);
    write_reg(pbpm_pkg::CfgChannels, 4'd1);
    push_byte(8'h7F, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b1);
    settle();
    write_reg(pbpm_pkg::CfgFormat, 4'(FmtCodeMax));
    push_byte(8'h3C, 1'b1);
    settle();
    write_reg(CfgSpare, 4'hF);
    push_byte(8'h11, 1'b1);
    settle();
    write_reg(pbpm_pkg::CfgFormat, 4'(pbpm_pkg::FmtU8));
    write_reg(pbpm_pkg::CfgChannels, 4'd15);
    for (int i = 0; i < pbpm_pkg::MaxChannelsDef; i++) begin
      push_byte(8'h40, i == pbpm_pkg::MaxChannelsDef - 1);
    end
    settle();
    write_reg(pbpm_pkg::CfgChannels, 4'd0);
    push_byte(8'h10, 1'b1);

    phase = 0;
    while (sent_items < ItemTarget) begin
      settle();
      if (phase < 8) write_reg(pbpm_pkg::CfgFormat, 4'(phase));
      else if ($urandom_range(0, 7) == 0)
        write_reg(pbpm_pkg::CfgFormat, 4'($urandom_range(pbpm_pkg::FmtNone, FmtCodeMax)));
      else
        write_reg(pbpm_pkg::CfgFormat, 4'($urandom_range(pbpm_pkg::FmtU8, pbpm_pkg::FmtS16)));
      write_reg(pbpm_pkg::CfgEndian, 4'($urandom_range(0, 1)));
      if (phase < 8) write_reg(pbpm_pkg::CfgChannels, chan_list[phase]);
      else if ($urandom_range(0, 7) == 0)
        write_reg(pbpm_pkg::CfgChannels, 4'($urandom_range(0, 15)));
      else
        write_reg(pbpm_pkg::CfgChannels, 4'($urandom_range(1, pbpm_pkg::MaxChannelsDef)));
      if ($urandom_range(0, 4) == 0) write_reg(CfgSpare, 4'($urandom));
      nbuf = (fmt_now >= pbpm_pkg::FmtNone) ? 2 : $urandom_range(4, 12);
      repeat (nbuf) send_buffer();
      // leave a buffer open so the next setting restarts it
      if ($urandom_range(0, 2) == 0) send_bytes($urandom_range(1, frame_len()), 1'b0);
      phase++;
    end

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pbpm_pkg.sv
hw/rtl/pbpm_front.sv
hw/rtl/pbpm_fifo.sv
hw/rtl/pbpm_back.sv
hw/rtl/pcm_buffer_peak_level_meter.sv
hw/rtl/pbpm_checker.sv
bench/volume_checker.sv
bench/testbench.sv
